// File: rtl/core/ppv_pkg.sv
// ----------------------------------------------------------------------------
// ppv_pkg
// Types, codes and character helpers shared by the path pattern validator.
// ----------------------------------------------------------------------------
package ppv_pkg;

  localparam int unsigned ChW   = 8;
  localparam int unsigned RuleW = 2;
  localparam int unsigned CfgIdxW = 2;

  // Rule codes, two's complement: 1 = required, -1 = forbidden, else free
  localparam logic signed [RuleW-1:0] RULE_POS = 2'sb01;
  localparam logic signed [RuleW-1:0] RULE_NEG = 2'sb11;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_START    = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_WILDCARD = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_END      = 2'd2;

  // Characters
  localparam logic [ChW-1:0] CH_NUL    = 8'h00;
  localparam logic [ChW-1:0] CH_SPACE  = 8'h20;
  localparam logic [ChW-1:0] CH_SLASH  = 8'h2F;
  localparam logic [ChW-1:0] CH_BSLASH = 8'h5C;
  localparam logic [ChW-1:0] CH_LBRACE = 8'h7B;
  localparam logic [ChW-1:0] CH_RBRACE = 8'h7D;
  localparam logic [ChW-1:0] CH_DEL    = 8'h7F;
  localparam logic [ChW-1:0] CH_ZERO   = 8'h30;
  localparam logic [ChW-1:0] CH_THREE  = 8'h33;
  localparam logic [ChW-1:0] CH_SEVEN  = 8'h37;

  typedef enum logic [1:0] {
    ESC_NONE = 2'd0,
    ESC_BSL  = 2'd1,
    ESC_OCT1 = 2'd2,
    ESC_OCT2 = 2'd3
  } esc_phase_t;

  typedef struct packed {
    logic signed [RuleW-1:0] start_rule;
    logic signed [RuleW-1:0] wildcard_rule;
    logic signed [RuleW-1:0] end_rule;
  } cfg_t;

  function automatic logic is_wild_class(input logic [ChW-1:0] c);
    return (c == "$") || (c == "+") || (c == "?") || (c == "*") || (c == "@") ||
           (c == "x") || (c == "X") || (c == "a") || (c == "A") || (c == "-");
  endfunction

  function automatic logic is_octal(input logic [ChW-1:0] c);
    return (c >= CH_ZERO) && (c <= CH_SEVEN);
  endfunction

endpackage

// File: rtl/core/ppv_in_if.sv
// ----------------------------------------------------------------------------
// ppv_in_if
// Byte channel into the validator: valid/ready with one path byte per beat.
// ----------------------------------------------------------------------------
interface ppv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;

  modport source (output valid, output ch, input ready);
  modport sink   (input valid, input ch, output ready);
endinterface

// File: rtl/core/ppv_out_if.sv
// ----------------------------------------------------------------------------
// ppv_out_if
// Verdict channel out of the validator: valid/ready with one flag per beat.
// ----------------------------------------------------------------------------
interface ppv_out_if;
  logic valid;
  logic ready;
  logic path_ok;

  modport source (output valid, output path_ok, input ready);
  modport sink   (input valid, input path_ok, output ready);
endinterface

// File: rtl/core/ppv_cfg.sv
// ----------------------------------------------------------------------------
// ppv_cfg
// Rule registers written through the plain configuration port.
// ----------------------------------------------------------------------------
module ppv_cfg (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [ppv_pkg::CfgIdxW-1:0] cfg_idx,
  input  logic [ppv_pkg::RuleW-1:0]  cfg_wdata,
  output ppv_pkg::cfg_t              cfg
);
  import ppv_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_idx)
        REG_START:    cfg_nxt.start_rule    = cfg_wdata;
        REG_WILDCARD: cfg_nxt.wildcard_rule = cfg_wdata;
        REG_END:      cfg_nxt.end_rule      = cfg_wdata;
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// File: rtl/core/ppv_step.sv
// ----------------------------------------------------------------------------
// ppv_step
// Per-string scan state and its combinational update for one path byte.
// ----------------------------------------------------------------------------
module ppv_step (
  input  logic                   clk,
  input  logic                   rst_n,
  input  ppv_pkg::cfg_t          cfg,
  input  logic                   beat,
  input  logic [ppv_pkg::ChW-1:0] ch,
  output logic                   verdict_valid,
  output logic                   verdict_ok
);
  import ppv_pkg::*;

  logic       failed_r, failed_nxt;
  esc_phase_t esc_r, esc_nxt;
  logic [1:0] oct_high_r, oct_high_nxt;
  logic [2:0] oct_mid_r, oct_mid_nxt;
  logic       esc_after_slash_r, esc_after_slash_nxt;
  logic       prev_slash_r, prev_slash_nxt;
  logic       need_slash_r, need_slash_nxt;
  logic       in_rep_r, in_rep_nxt;
  logic       has_wild_r, has_wild_nxt;
  logic       at_first_r, at_first_nxt;
  logic [8:0] oct_val;
  logic       wild_neg;

  assign wild_neg = (cfg.wildcard_rule == RULE_NEG);
  assign oct_val  = {oct_high_r, oct_mid_r, ch[2:0]} + 9'd0;

  always_comb begin
    failed_nxt          = failed_r;
    esc_nxt             = esc_r;
    oct_high_nxt        = oct_high_r;
    oct_mid_nxt         = oct_mid_r;
    esc_after_slash_nxt = esc_after_slash_r;
    prev_slash_nxt      = prev_slash_r;
    need_slash_nxt      = need_slash_r;
    in_rep_nxt          = in_rep_r;
    has_wild_nxt        = has_wild_r;
    at_first_nxt        = at_first_r;
    verdict_valid       = 1'b0;
    verdict_ok          = 1'b0;

    if (at_first_r) begin
      if ((cfg.start_rule == RULE_POS) && (ch != CH_SLASH)) failed_nxt = 1'b1;
      if ((cfg.start_rule == RULE_NEG) && (ch == CH_SLASH)) failed_nxt = 1'b1;
      at_first_nxt = 1'b0;
    end

    if (ch == CH_NUL) begin
      verdict_valid = beat;
      verdict_ok    = !failed_nxt;
      if ((cfg.end_rule == RULE_POS) && !prev_slash_r) verdict_ok = 1'b0;
      if ((cfg.end_rule == RULE_NEG) && prev_slash_r)  verdict_ok = 1'b0;
      if ((esc_r != ESC_NONE) || need_slash_r || in_rep_r) verdict_ok = 1'b0;
      if ((cfg.wildcard_rule == RULE_POS) && !has_wild_r) verdict_ok = 1'b0;
      // start over for the next string
      failed_nxt          = 1'b0;
      esc_nxt             = ESC_NONE;
      oct_high_nxt        = '0;
      oct_mid_nxt         = '0;
      esc_after_slash_nxt = 1'b0;
      prev_slash_nxt      = 1'b0;
      need_slash_nxt      = 1'b0;
      in_rep_nxt          = 1'b0;
      has_wild_nxt        = 1'b0;
      at_first_nxt        = 1'b1;
    end else begin
      if (need_slash_r) begin
        if (ch != CH_SLASH) failed_nxt = 1'b1;
        need_slash_nxt = 1'b0;
      end

      case (esc_r)
        ESC_BSL: begin
          esc_nxt = ESC_NONE;
          if (ch == CH_BSLASH) begin
            esc_nxt = ESC_NONE;
          end else if (is_wild_class(ch)) begin
            if (wild_neg) failed_nxt = 1'b1;
            else has_wild_nxt = 1'b1;
          end else if (ch == CH_LBRACE) begin
            if (!esc_after_slash_r || wild_neg) begin
              failed_nxt = 1'b1;
            end else begin
              has_wild_nxt = 1'b1;
              in_rep_nxt   = 1'b1;
            end
          end else if (ch == CH_RBRACE) begin
            if (!in_rep_r) begin
              failed_nxt = 1'b1;
            end else begin
              in_rep_nxt     = 1'b0;
              need_slash_nxt = 1'b1;
            end
          end else if ((ch >= CH_ZERO) && (ch <= CH_THREE)) begin
            oct_high_nxt = ch[1:0];
            esc_nxt      = ESC_OCT1;
          end else begin
            failed_nxt = 1'b1;
          end
        end
        ESC_OCT1: begin
          if (is_octal(ch)) begin
            oct_mid_nxt = ch[2:0];
            esc_nxt     = ESC_OCT2;
          end else begin
            failed_nxt = 1'b1;
            esc_nxt    = ESC_NONE;
          end
        end
        ESC_OCT2: begin
          esc_nxt = ESC_NONE;
          if (is_octal(ch)) begin
            // reject NUL and anything that could have been written plainly
            if ((oct_val == 9'd0) ||
                ((oct_val > {1'b0, CH_SPACE}) && (oct_val < {1'b0, CH_DEL}))) begin
              failed_nxt = 1'b1;
            end
          end else begin
            failed_nxt = 1'b1;
          end
        end
        default: begin
          if (ch == CH_BSLASH) begin
            esc_after_slash_nxt = prev_slash_r;
            esc_nxt             = ESC_BSL;
          end else if (in_rep_r && (ch == CH_SLASH)) begin
            failed_nxt = 1'b1;
          end else if ((ch <= CH_SPACE) || (ch >= CH_DEL)) begin
            failed_nxt = 1'b1;
          end
        end
      endcase

      prev_slash_nxt = (ch == CH_SLASH);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      failed_r          <= 1'b0;
      esc_r             <= ESC_NONE;
      oct_high_r        <= '0;
      oct_mid_r         <= '0;
      esc_after_slash_r <= 1'b0;
      prev_slash_r      <= 1'b0;
      need_slash_r      <= 1'b0;
      in_rep_r          <= 1'b0;
      has_wild_r        <= 1'b0;
      at_first_r        <= 1'b1;
    end else if (beat) begin
      failed_r          <= failed_nxt;
      esc_r             <= esc_nxt;
      oct_high_r        <= oct_high_nxt;
      oct_mid_r         <= oct_mid_nxt;
      esc_after_slash_r <= esc_after_slash_nxt;
      prev_slash_r      <= prev_slash_nxt;
      need_slash_r      <= need_slash_nxt;
      in_rep_r          <= in_rep_nxt;
      has_wild_r        <= has_wild_nxt;
      at_first_r        <= at_first_nxt;
    end
  end

  a_term_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (beat && (ch == CH_NUL)) |=> (at_first_r && !failed_r && (esc_r == ESC_NONE)))
    else $error("scan state not cleared after terminator");

  a_first_no_escape: assert property (@(posedge clk) disable iff (!rst_n)
    at_first_r |-> ((esc_r == ESC_NONE) && !in_rep_r && !need_slash_r && !has_wild_r))
    else $error("string state present before first byte");

  a_group_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_rep_r && need_slash_r))
    else $error("open group and pending close slash at once");

endmodule

// File: rtl/core/path_pattern_validator_top.sv
// ----------------------------------------------------------------------------
// path_pattern_validator_top
// Checks a byte stream of path strings and gives one pass/fail per string.
// ----------------------------------------------------------------------------
// Usage:
//   in_if  : one path byte per beat; a zero byte ends the string.
//   out_if : one beat per string, path_ok = 1 when all rules hold.
//   cfg_*  : write start, wildcard and end rules (index 0, 1, 2) while the
//            block is idle; each takes effect from the next byte on.
// Timing:
//   A byte is taken every cycle unless a stall holds input ready low. The
//   scan state is updated in the cycle the byte is accepted; the verdict
//   for a terminator appears in the output register in the cycle after
//   acceptance. Throughput is one byte per cycle outside stalls, set by the
//   combinational update of the scan state registers.
// Stall:
//   While a verdict waits in the output register and the receiver holds
//   ready low, input ready drops; a taken verdict frees the register in
//   the same cycle, so back-to-back strings run at full rate.
// Reset:
//   Synchronous rst_n clears rules to free, scan state to string start and
//   the output register to empty.
// ----------------------------------------------------------------------------
module path_pattern_validator_top (
  input  logic                        clk,
  input  logic                        rst_n,
  ppv_in_if.sink                      in_if,
  ppv_out_if.source                   out_if,
  input  logic                        cfg_we,
  input  logic [ppv_pkg::CfgIdxW-1:0] cfg_idx,
  input  logic [ppv_pkg::RuleW-1:0]   cfg_wdata
);
  import ppv_pkg::*;

  cfg_t cfg;
  logic in_beat;
  logic verdict_valid;
  logic verdict_ok;
  logic out_valid_r, out_valid_nxt;
  logic out_ok_r, out_ok_nxt;

  assign in_if.ready = !out_valid_r || out_if.ready;
  assign in_beat     = in_if.valid && in_if.ready;

  ppv_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  ppv_step u_step (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg),
    .beat          (in_beat),
    .ch            (in_if.ch),
    .verdict_valid (verdict_valid),
    .verdict_ok    (verdict_ok)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_ok_nxt    = out_ok_r;
    if (out_valid_r && out_if.ready) out_valid_nxt = 1'b0;
    if (verdict_valid) begin
      out_valid_nxt = 1'b1;
      out_ok_nxt    = verdict_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_ok_r <= out_ok_nxt;
  end

  assign out_if.valid   = out_valid_r;
  assign out_if.path_ok = out_ok_r;

  a_term_gives_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    (in_beat && (in_if.ch == CH_NUL)) |=> out_valid_r)
    else $error("terminator accepted without a verdict");

  a_byte_no_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid_r && in_beat && (in_if.ch != CH_NUL)) |=> !out_valid_r)
    else $error("verdict raised for a plain byte");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_if.ready) |-> !verdict_valid)
    else $error("pending verdict overwritten");

endmodule

// File: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives path strings into the path pattern validator one byte per beat and
// checks each verdict against a cycle-free scanner kept alongside the block.
// Covers directed corner strings, a long output stall and random phases of
// well-formed, broken and noise strings under changing rule settings.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ppv_pkg::*;

  localparam int ClkPeriod   = 4;
  localparam int LimitCycles = 1_000_000;
  localparam int RandomBytes = 2000;

  // Rule codes the package leaves unnamed; both mean "free"
  localparam logic signed [RuleW-1:0] RULE_FREE  = 2'sb00;
  localparam logic signed [RuleW-1:0] RULE_SPARE = 2'sb10;

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [RuleW-1:0]   cfg_wdata;

  ppv_in_if  in_ch ();
  ppv_out_if out_ch ();

  path_pattern_validator_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_ch),
    .out_if    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  // Scanner state, mirrors the block between beats
  cfg_t       rules;
  logic       path_failed;
  esc_phase_t esc_state;
  logic [1:0] oct_hi;
  logic [2:0] oct_mid;
  logic       esc_after_slash;
  logic       prev_slash;
  logic       need_slash;
  logic       in_group;
  logic       saw_wildcard;
  logic       at_first;

  logic       verdict_q[$];
  logic [7:0] path_q[$];
  int         fail_count  = 0;
  int         bytes_sent  = 0;
  int         rx_hold_req = 0;
  bit         tx_steady   = 0;
  bit         rx_steady   = 0;

  initial begin
    clk = 1'b0;
    forever #(ClkPeriod / 2) clk = ~clk;
  end

  initial begin : watchdog
    #(ClkPeriod * LimitCycles);
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic logic [7:0] wild_byte(input int i);
    case (i)
      0: return "$";
      1: return "+";
      2: return "?";
      3: return "*";
      4: return "@";
      5: return "x";
      6: return "X";
      7: return "a";
      8: return "A";
      default: return "-";
    endcase
  endfunction

  function automatic logic is_wildcard(input logic [7:0] c);
    for (int i = 0; i < 10; i++) begin
      if (c == wild_byte(i)) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [RuleW-1:0] rand_rule();
    case ($urandom_range(0, 3))
      0: return RULE_POS;
      1: return RULE_NEG;
      2: return RULE_FREE;
      default: return RULE_SPARE;
    endcase
  endfunction

  function automatic logic [7:0] plain_byte();
    logic [7:0] c;
    do c = 8'($urandom_range(33, 126)); while (c == CH_SLASH || c == CH_BSLASH);
    return c;
  endfunction

  task automatic clear_scan();
    path_failed     = 1'b0;
    esc_state       = ESC_NONE;
    oct_hi          = '0;
    oct_mid         = '0;
    esc_after_slash = 1'b0;
    prev_slash      = 1'b0;
    need_slash      = 1'b0;
    in_group        = 1'b0;
    saw_wildcard    = 1'b0;
    at_first        = 1'b1;
  endtask

  // Advance the scanner by one accepted byte; a terminator queues a verdict
  task automatic scan_byte(input logic [7:0] c);
    logic       ok;
    logic [7:0] oct_val;
    if (at_first) begin
      if (rules.start_rule == RULE_POS && c != CH_SLASH) path_failed = 1'b1;
      if (rules.start_rule == RULE_NEG && c == CH_SLASH) path_failed = 1'b1;
      at_first = 1'b0;
    end
    if (c == CH_NUL) begin
      ok = !path_failed;
      if (rules.end_rule == RULE_POS && !prev_slash) ok = 1'b0;
      if (rules.end_rule == RULE_NEG && prev_slash) ok = 1'b0;
      if (esc_state != ESC_NONE || need_slash || in_group) ok = 1'b0;
      if (rules.wildcard_rule == RULE_POS && !saw_wildcard) ok = 1'b0;
      verdict_q.push_back(ok);
      clear_scan();
    end else begin
      if (need_slash) begin
        if (c != CH_SLASH) path_failed = 1'b1;
        need_slash = 1'b0;
      end
      case (esc_state)
        ESC_BSL: begin
          esc_state = ESC_NONE;
          if (c == CH_BSLASH) begin
            // doubled backslash, nothing to track
          end else if (is_wildcard(c)) begin
            if (rules.wildcard_rule == RULE_NEG) path_failed = 1'b1;
            else saw_wildcard = 1'b1;
          end else if (c == CH_LBRACE) begin
            if (!esc_after_slash || rules.wildcard_rule == RULE_NEG) begin
              path_failed = 1'b1;
            end else begin
              saw_wildcard = 1'b1;
              in_group     = 1'b1;
            end
          end else if (c == CH_RBRACE) begin
            if (!in_group) begin
              path_failed = 1'b1;
            end else begin
              in_group   = 1'b0;
              need_slash = 1'b1;
            end
          end else if (c >= CH_ZERO && c <= CH_THREE) begin
            oct_hi    = c[1:0];
            esc_state = ESC_OCT1;
          end else begin
            path_failed = 1'b1;
          end
        end
        ESC_OCT1: begin
          if (c >= CH_ZERO && c <= CH_SEVEN) begin
            oct_mid   = c[2:0];
            esc_state = ESC_OCT2;
          end else begin
            path_failed = 1'b1;
            esc_state   = ESC_NONE;
          end
        end
        ESC_OCT2: begin
          esc_state = ESC_NONE;
          oct_val   = {oct_hi, oct_mid, c[2:0]};
          if (c < CH_ZERO || c > CH_SEVEN || oct_val == CH_NUL ||
              (oct_val > CH_SPACE && oct_val < CH_DEL)) begin
            path_failed = 1'b1;
          end
        end
        default: begin
          if (c == CH_BSLASH) begin
            esc_after_slash = prev_slash;
            esc_state       = ESC_BSL;
          end else if (in_group && c == CH_SLASH) begin
            path_failed = 1'b1;
          end else if (c <= CH_SPACE || c >= CH_DEL) begin
            path_failed = 1'b1;
          end
        end
      endcase
      prev_slash = (c == CH_SLASH);
    end
  endtask

  // Input beats are scanned before output beats are checked at each edge
  always @(posedge clk) begin
    logic exp_ok;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) scan_byte(in_ch.ch);
      if (out_ch.valid && out_ch.ready) begin
        if (verdict_q.size() == 0) begin
          $error("path_ok: no verdict expected, got %0b", out_ch.path_ok);
          fail_count++;
        end else begin
          exp_ok = verdict_q.pop_front();
          if (out_ch.path_ok !== exp_ok) begin
            $error("path_ok: expected %0b, got %0b", exp_ok, out_ch.path_ok);
            fail_count++;
          end
        end
      end
    end
  end

  // Result side: random stalls, or a long hold-off when one is requested
  initial begin : verdict_sink
    int stall;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (rx_hold_req > 0) begin
        stall       = rx_hold_req;
        rx_hold_req = 0;
      end else if (rx_steady) begin
        stall = 0;
      end else begin
        stall = gap_len();
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int n;
    in_ch.valid <= 1'b1;
    in_ch.ch    <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    bytes_sent++;
    n = tx_steady ? 0 : gap_len();
    if (n > 0) begin
      in_ch.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic send_path();
    foreach (path_q[i]) send_byte(path_q[i]);
    send_byte(CH_NUL);
  endtask

  task automatic send_text(input string s);
    path_q.delete();
    for (int i = 0; i < s.len(); i++) path_q.push_back(s[i]);
    send_path();
  endtask

  // Drop valid and hold until every verdict is in, then let the block settle
  task automatic wait_verdicts_done();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic set_rules(input logic signed [RuleW-1:0] s_rule,
                           input logic signed [RuleW-1:0] w_rule,
                           input logic signed [RuleW-1:0] e_rule);
    cfg_we    <= 1'b1;
    cfg_idx   <= REG_START;
    cfg_wdata <= s_rule;
    @(posedge clk);
    cfg_idx   <= REG_WILDCARD;
    cfg_wdata <= w_rule;
    @(posedge clk);
    cfg_idx   <= REG_END;
    cfg_wdata <= e_rule;
    @(posedge clk);
    cfg_we <= 1'b0;
    rules.start_rule    = s_rule;
    rules.wildcard_rule = w_rule;
    rules.end_rule      = e_rule;
  endtask

  task automatic add_tokens(input int n);
    logic [7:0] v;
    for (int t = 0; t < n; t++) begin
      case ($urandom_range(0, 9))
        0: begin
          path_q.push_back(CH_BSLASH);
          path_q.push_back(CH_BSLASH);
        end
        1: begin
          path_q.push_back(CH_BSLASH);
          path_q.push_back(wild_byte($urandom_range(0, 9)));
        end
        2: begin
          // octal escape of a nonzero value that could not be written plainly
          do v = 8'($urandom_range(1, 255)); while (v > CH_SPACE && v < CH_DEL);
          path_q.push_back(CH_BSLASH);
          path_q.push_back(CH_ZERO + v[7:6]);
          path_q.push_back(CH_ZERO + v[5:3]);
          path_q.push_back(CH_ZERO + v[2:0]);
        end
        default: path_q.push_back(plain_byte());
      endcase
    end
  endtask

  task automatic build_path();
    int n_seg;
    path_q.delete();
    n_seg = $urandom_range(0, 3);
    if ($urandom_range(0, 1) == 1) path_q.push_back(CH_SLASH);
    for (int s = 0; s < n_seg; s++) begin
      if (s > 0) path_q.push_back(CH_SLASH);
      if (path_q.size() > 0 && path_q[$] == CH_SLASH && $urandom_range(0, 3) == 0) begin
        path_q.push_back(CH_BSLASH);
        path_q.push_back(CH_LBRACE);
        add_tokens($urandom_range(0, 3));
        path_q.push_back(CH_BSLASH);
        path_q.push_back(CH_RBRACE);
        path_q.push_back(CH_SLASH);
      end else begin
        add_tokens($urandom_range(1, 4));
      end
    end
    if ($urandom_range(0, 1) == 1) path_q.push_back(CH_SLASH);
  endtask

  task automatic test_directed();
    set_rules(RULE_POS, RULE_POS, RULE_POS);
    send_text("");
    wait_verdicts_done();
    set_rules(RULE_NEG, RULE_NEG, RULE_NEG);
    send_text("");
    wait_verdicts_done();
    set_rules(RULE_SPARE, RULE_SPARE, RULE_SPARE);
    path_q.delete();
    path_q.push_back(8'hFF);
    send_path();
    send_text("\\");
    send_text("/\\{\\}/");
    send_text("\\{");
    send_text("/\\{a\\}");
    send_text("\\001");
    wait_verdicts_done();
  endtask

  // Hold the result side off while the sender keeps offering bytes
  task automatic test_backpressure();
    set_rules(RULE_FREE, RULE_FREE, RULE_FREE);
    tx_steady   = 1'b1;
    rx_hold_req = 200;
    for (int i = 0; i < 40; i++) begin
      build_path();
      send_path();
    end
    tx_steady = 1'b0;
    wait_verdicts_done();
  endtask

  task automatic test_random();
    int left_in_phase;
    int pos;
    left_in_phase = 0;
    while (bytes_sent < RandomBytes) begin
      if (left_in_phase == 0) begin
        wait_verdicts_done();
        set_rules(rand_rule(), rand_rule(), rand_rule());
        tx_steady     = ($urandom_range(0, 3) == 0);
        rx_steady     = ($urandom_range(0, 3) == 0);
        left_in_phase = $urandom_range(8, 25);
      end
      left_in_phase--;
      case ($urandom_range(0, 9))
        0: begin
          path_q.delete();
          repeat ($urandom_range(0, 6)) path_q.push_back(8'($urandom_range(1, 255)));
        end
        1, 2: begin
          build_path();
          case ($urandom_range(0, 3))
            0: if (path_q.size() > 0) begin
              path_q[$urandom_range(0, path_q.size() - 1)] = 8'($urandom_range(1, 255));
            end
            1: if (path_q.size() > 0) path_q.delete($urandom_range(0, path_q.size() - 1));
            2: path_q.push_back(CH_BSLASH);
            default: begin
              pos = $urandom_range(0, path_q.size());
              path_q.insert(pos, CH_BSLASH);
              path_q.insert(pos + 1, 8'($urandom_range(1, 255)));
            end
          endcase
        end
        default: build_path();
      endcase
      send_path();
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
    wait_verdicts_done();
  endtask

  initial begin
    rst_n       <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.ch    <= CH_NUL;
    cfg_we      <= 1'b0;
    cfg_idx     <= REG_START;
    cfg_wdata   <= RULE_FREE;
    rules        = '0;
    clear_scan();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_backpressure();
    test_random();

    if (fail_count == 0 && verdict_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: path_pattern_validator_top.f
rtl/core/ppv_pkg.sv
rtl/core/ppv_in_if.sv
rtl/core/ppv_out_if.sv
rtl/core/ppv_cfg.sv
rtl/core/ppv_step.sv
rtl/core/path_pattern_validator_top.sv
tb/sv/testbench.sv
